// ===== src/dfr_pkg.sv =====
package dfr_pkg;

  localparam int NUM_CONNECTIONS = 256;
  localparam int CONN_W = 8;
  localparam int ADDR_W = $clog2(NUM_CONNECTIONS);

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_CLOSE = 1'b1;

  localparam logic [1:0] PH_HIGH = 2'd0;
  localparam logic [1:0] PH_LOW = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  header_high;
    logic [15:0] bytes_left;
    logic        started;
  } entry_t;

  typedef struct packed {
    logic [1:0]        out_kind;
    logic [CONN_W-1:0] out_conn;
    logic [7:0]        payload;
    logic              first_of_packet;
    logic              last_of_packet;
    logic              dropped_partial;
  } result_t;

  typedef struct packed {
    entry_t  nxt;
    logic    has_res;
    result_t res;
  } step_t;

  function automatic step_t dfr_step(input logic req_type, input logic [CONN_W-1:0] conn,
                                     input logic [7:0] data, input entry_t cur);
    step_t       s;
    logic [15:0] len;
    logic [15:0] left;
    s = '0;
    s.nxt = cur;
    s.res.out_conn = conn;
    len = {cur.header_high, data};
    left = (cur.bytes_left == 16'd0) ? 16'd0 : cur.bytes_left - 16'd1;
    if (req_type == REQ_CLOSE) begin
      s.nxt = '0;
      s.has_res = 1'b1;
      s.res.out_kind = KIND_CLOSE;
      s.res.dropped_partial = (cur.phase != PH_HIGH);
    end else begin
      case (cur.phase)
        PH_LOW: begin
          if (len == 16'd0) begin
            s.nxt = '0;
            s.has_res = 1'b1;
            s.res.out_kind = KIND_EMPTY;
            s.res.last_of_packet = 1'b1;
          end else begin
            s.nxt.phase = PH_BODY;
            s.nxt.bytes_left = len;
            s.nxt.started = 1'b0;
          end
        end
        PH_BODY: begin
          s.has_res = 1'b1;
          s.res.out_kind = KIND_BYTE;
          s.res.payload = data;
          s.res.first_of_packet = ~cur.started;
          s.res.last_of_packet = (left == 16'd0);
          if (left == 16'd0) begin
            s.nxt = '0;
          end else begin
            s.nxt.bytes_left = left;
            s.nxt.started = 1'b1;
          end
        end
        default: begin
          s.nxt.header_high = data;
          s.nxt.phase = PH_LOW;
        end
      endcase
    end
    return s;
  endfunction

endpackage

// ===== src/dfr_if.sv =====
interface dfr_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] conn_id;
  logic [7:0] data_byte;

  modport source (output valid, req_type, conn_id, data_byte, input ready);
  modport sink (input valid, req_type, conn_id, data_byte, output ready);
endinterface

interface dfr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_conn;
  logic [7:0] payload;
  logic       first_of_packet;
  logic       last_of_packet;
  logic       dropped_partial;

  modport source (output valid, out_kind, out_conn, payload, first_of_packet,
                  last_of_packet, dropped_partial, input ready);
  modport sink (input valid, out_kind, out_conn, payload, first_of_packet,
                last_of_packet, dropped_partial, output ready);
endinterface

// ===== src/dfr_state_store.sv =====
module dfr_state_store (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [7:0]            rd_addr,
  output dfr_pkg::entry_t       rd_data,
  input  logic                  wr_en,
  input  logic [7:0]            wr_addr,
  input  dfr_pkg::entry_t       wr_data
);
  import dfr_pkg::*;

  entry_t                     mem [NUM_CONNECTIONS];
  logic [NUM_CONNECTIONS-1:0] written;
  entry_t                     rd_word;
  logic                       rd_written;

  // storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr[ADDR_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr[ADDR_W-1:0]];
      end
    end
  end

  assign rd_data = rd_written ? rd_word : '0;
endmodule

// ===== src/dfr_out_reg.sv =====
module dfr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dfr_pkg::result_t data,
  output logic             free,
  dfr_res_if.source        res
);
  import dfr_pkg::*;

  logic    valid;
  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign free = ~valid | res.ready;
  assign res.valid = valid;
  assign res.out_kind = held.out_kind;
  assign res.out_conn = held.out_conn;
  assign res.payload = held.payload;
  assign res.first_of_packet = held.first_of_packet;
  assign res.last_of_packet = held.last_of_packet;
  assign res.dropped_partial = held.dropped_partial;
endmodule

// ===== src/multi_channel_length_prefix_deframer.sv =====
// Length-prefix deframer for up to 256 interleaved connections.
// byte_req carries one stream byte (req_type data) or a close notice
// (req_type close) tagged with its connection number. Each connection's
// stream is a run of packets: 16-bit big-endian length, then payload.
// res carries one result per payload byte (with first/last marks), one
// empty-packet result per zero length, and one notice per close that says
// whether an unfinished packet was dropped. Header bytes give no result.
// Per-connection state sits in a 256-entry synchronous memory read when the
// request is accepted; the update is written back as the request leaves the
// update stage, with a bypass for back-to-back requests to the same
// connection. Throughput: one request per cycle while res does not stall.
// A result is computed in the update stage and held in the output register.
// Reset clears the per-connection written flags at once, so every
// connection starts awaiting a header; no clearing pass is needed and the
// block accepts requests from the first cycle after reset.
// When res stalls, one result waits in the output register and the request
// behind it waits in the update stage; byte_req.ready then drops.
module multi_channel_length_prefix_deframer (
  input  logic      clk,
  input  logic      rst,
  dfr_req_if.sink   byte_req,
  dfr_res_if.source res
);
  import dfr_pkg::*;

  logic        accept;
  logic        slot_free;
  logic        s1_valid;
  logic        s1_adv;
  logic        s1_req;
  logic [7:0]  s1_conn;
  logic [7:0]  s1_byte;
  logic        s1_hit;
  entry_t      s1_fwd;
  entry_t      rd_data;
  entry_t      cur;
  step_t       step;

  assign byte_req.ready = ~s1_valid | slot_free;
  assign accept = byte_req.valid & byte_req.ready;
  assign s1_adv = s1_valid & slot_free;

  dfr_state_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (byte_req.conn_id),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_conn),
    .wr_data (step.nxt)
  );

  assign cur = s1_hit ? s1_fwd : rd_data;
  assign step = dfr_step(s1_req, s1_conn, s1_byte, cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_hit <= 1'b0;
    end else if (byte_req.ready) begin
      s1_valid <= accept;
      s1_hit <= accept & s1_adv & (byte_req.conn_id == s1_conn);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= byte_req.req_type;
      s1_conn <= byte_req.conn_id;
      s1_byte <= byte_req.data_byte;
      s1_fwd <= step.nxt;
    end
  end

  dfr_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (s1_adv & step.has_res),
    .data (step.res),
    .free (slot_free),
    .res  (res)
  );
endmodule

// ===== src/dfr_checker.sv =====
module dfr_prop_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] out_kind,
  input logic [7:0] payload,
  input logic       first_of_packet,
  input logic       last_of_packet,
  input logic       dropped_partial
);
  import dfr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(payload) && $stable(out_kind))
    else $error("stalled result changed");

  a_close: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_kind == KIND_CLOSE |-> !first_of_packet && !last_of_packet
      && payload == 8'd0)
    else $error("close notice carries packet marks");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_kind == KIND_EMPTY |-> last_of_packet && !first_of_packet
      && !dropped_partial && payload == 8'd0)
    else $error("bad empty packet result");

  a_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_kind == KIND_BYTE |-> !dropped_partial)
    else $error("payload byte flags a drop");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result right after reset");
endmodule

bind multi_channel_length_prefix_deframer dfr_prop_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .out_kind        (res.out_kind),
  .payload         (res.payload),
  .first_of_packet (res.first_of_packet),
  .last_of_packet  (res.last_of_packet),
  .dropped_partial (res.dropped_partial)
);

// ===== tb/dfr_checker.sv =====
`timescale 1ns / 100ps

module dfr_checker (
  input  logic clk,
  input  logic rst,
  dfr_req_if   req_mon,
  dfr_res_if   res_mon,
  output int   fail_count,
  output int   pending
);
  import dfr_pkg::*;

  logic [1:0]  phase_mem   [NUM_CONNECTIONS];
  logic [7:0]  hdr_hi_mem  [NUM_CONNECTIONS];
  logic [15:0] left_mem    [NUM_CONNECTIONS];
  logic        started_mem [NUM_CONNECTIONS];

  result_t frame_results_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic clear_conn(input logic [7:0] c);
    phase_mem[c] = PH_HIGH;
    hdr_hi_mem[c] = 8'd0;
    left_mem[c] = 16'd0;
    started_mem[c] = 1'b0;
  endtask

  // work out what one accepted request should give and advance the state
  task automatic deframe_request(input logic rt, input logic [7:0] c, input logic [7:0] d);
    result_t     r;
    logic [15:0] len;
    logic [15:0] left;
    bit          in_range;
    r = '0;
    r.out_conn = c;
    in_range = (int'(c) < NUM_CONNECTIONS);
    if (rt == REQ_CLOSE) begin
      r.out_kind = KIND_CLOSE;
      if (in_range) begin
        r.dropped_partial = (phase_mem[c] != PH_HIGH);
        clear_conn(c);
      end
      frame_results_q.push_back(r);
    end else if (in_range) begin
      case (phase_mem[c])
        PH_LOW: begin
          len = {hdr_hi_mem[c], d};
          if (len == 16'd0) begin
            clear_conn(c);
            r.out_kind = KIND_EMPTY;
            r.last_of_packet = 1'b1;
            frame_results_q.push_back(r);
          end else begin
            left_mem[c] = len;
            started_mem[c] = 1'b0;
            phase_mem[c] = PH_BODY;
          end
        end
        PH_BODY: begin
          left = (left_mem[c] == 16'd0) ? 16'd0 : left_mem[c] - 16'd1;
          r.out_kind = KIND_BYTE;
          r.payload = d;
          r.first_of_packet = ~started_mem[c];
          r.last_of_packet = (left == 16'd0);
          if (left == 16'd0) begin
            clear_conn(c);
          end else begin
            left_mem[c] = left;
            started_mem[c] = 1'b1;
          end
          frame_results_q.push_back(r);
        end
        // unused phase value counts as awaiting the high header byte
        default: begin
          hdr_hi_mem[c] = d;
          phase_mem[c] = PH_LOW;
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (frame_results_q.size() == 0) begin
      fail_count++;
      $display("%0t: result with none expected, kind %0d conn %0d payload %0d",
               $time, res_mon.out_kind, res_mon.out_conn, res_mon.payload);
    end else begin
      want = frame_results_q.pop_front();
      check_field("out_kind", int'(want.out_kind), int'(res_mon.out_kind));
      check_field("out_conn", int'(want.out_conn), int'(res_mon.out_conn));
      check_field("payload", int'(want.payload), int'(res_mon.payload));
      check_field("first_of_packet", int'(want.first_of_packet),
                  int'(res_mon.first_of_packet));
      check_field("last_of_packet", int'(want.last_of_packet),
                  int'(res_mon.last_of_packet));
      check_field("dropped_partial", int'(want.dropped_partial),
                  int'(res_mon.dropped_partial));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CONNECTIONS; i++) begin
        clear_conn(i[7:0]);
      end
      frame_results_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        check_result();
      end
      if (req_mon.valid && req_mon.ready) begin
        deframe_request(req_mon.req_type, req_mon.conn_id, req_mon.data_byte);
      end
    end
    pending = frame_results_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dfr_pkg::*;

  localparam int POOL = 4;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst;

  dfr_req_if byte_req ();
  dfr_res_if res ();

  int fail_count;
  int pending;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_start;
  int hold_left;
  int stall_cnt;

  // per-slot framing progress of the well-formed streams
  logic [7:0]  slot_conn [POOL];
  int          slot_hdr  [POOL];
  logic [15:0] slot_len  [POOL];
  int          slot_body [POOL];
  int          slot_cut  [POOL];

  multi_channel_length_prefix_deframer i_dut (
    .clk      (clk),
    .rst      (rst),
    .byte_req (byte_req),
    .res      (res)
  );

  dfr_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (byte_req),
    .res_mon    (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  initial begin
    rst = 1'b1;
    byte_req.valid = 1'b0;
    byte_req.req_type = REQ_DATA;
    byte_req.conn_id = 8'd0;
    byte_req.data_byte = 8'd0;
    res.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_start = 1'b0;
    hold_left = 0;
    stall_cnt = 0;
  end

  // receiver side, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready = 1'b0;
    end else begin
      res.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_req.valid && byte_req.ready) || (res.valid && res.ready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic rt, input logic [7:0] c, input logic [7:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_req.valid = 1'b0;
      @(negedge clk);
    end
    byte_req.valid = 1'b1;
    byte_req.req_type = rt;
    byte_req.conn_id = c;
    byte_req.data_byte = d;
    @(posedge clk);
    while (!byte_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    byte_req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic new_packet(input int s);
    int r;
    r = $urandom_range(0, 99);
    slot_cut[s] = -1;
    if (r < 10) begin
      slot_len[s] = 16'd0;
    end else if (r < 80) begin
      slot_len[s] = 16'($urandom_range(1, 8));
    end else if (r < 85) begin
      slot_len[s] = 16'($urandom_range(200, 300));
    end else begin
      // broken packet: any length, closed early
      slot_len[s] = 16'($urandom_range(0, 65535));
      slot_cut[s] = $urandom_range(1, 6);
    end
    slot_hdr[s] = 2;
  endtask

  task automatic slot_step(input int s);
    if (slot_hdr[s] == 0 && slot_body[s] == 0) new_packet(s);
    if (slot_cut[s] == 0) begin
      send_request(REQ_CLOSE, slot_conn[s], 8'($urandom_range(0, 255)));
      slot_hdr[s] = 0;
      slot_body[s] = 0;
      slot_cut[s] = -1;
    end else begin
      if (slot_hdr[s] == 2) begin
        send_request(REQ_DATA, slot_conn[s], slot_len[s][15:8]);
        slot_hdr[s] = 1;
      end else if (slot_hdr[s] == 1) begin
        send_request(REQ_DATA, slot_conn[s], slot_len[s][7:0]);
        slot_hdr[s] = 0;
        slot_body[s] = int'(slot_len[s]);
      end else begin
        send_request(REQ_DATA, slot_conn[s], 8'($urandom_range(0, 255)));
        slot_body[s]--;
      end
      if (slot_cut[s] > 0) slot_cut[s]--;
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit do_hold);
    int r;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    // fresh set of connections, each closed first to start clean
    for (int s = 0; s < POOL; s++) begin
      slot_conn[s] = 8'($urandom_range(0, 255));
      slot_hdr[s] = 0;
      slot_body[s] = 0;
      slot_cut[s] = -1;
      send_request(REQ_CLOSE, slot_conn[s], 8'($urandom_range(0, 255)));
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (do_hold && n == PHASE_ITEMS / 2) hold_start = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 85) begin
        slot_step($urandom_range(0, POOL - 1));
      end else if (r < 92) begin
        send_request(REQ_CLOSE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        send_request(REQ_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: close with nothing pending, empty packet, single-byte packet
    send_request(REQ_CLOSE, 8'h00, 8'hFF);
    send_request(REQ_DATA, 8'h00, 8'h00);
    send_request(REQ_DATA, 8'h00, 8'h00);
    send_request(REQ_DATA, 8'hFF, 8'h00);
    send_request(REQ_DATA, 8'hFF, 8'h01);
    send_request(REQ_DATA, 8'hFF, 8'hFF);
    // interleaved: three-byte packet beside a maximum length one closed mid payload
    send_request(REQ_DATA, 8'h5A, 8'h00);
    send_request(REQ_DATA, 8'h5A, 8'h03);
    send_request(REQ_DATA, 8'hA5, 8'hFF);
    send_request(REQ_DATA, 8'h5A, 8'h00);
    send_request(REQ_DATA, 8'hA5, 8'hFF);
    send_request(REQ_DATA, 8'h5A, 8'hAA);
    send_request(REQ_DATA, 8'h5A, 8'h55);
    send_request(REQ_DATA, 8'hA5, 8'h12);
    send_request(REQ_CLOSE, 8'hA5, 8'h00);
    // close after the high header byte only
    send_request(REQ_DATA, 8'h3C, 8'h80);
    send_request(REQ_CLOSE, 8'h3C, 8'h00);
    send_request(REQ_DATA, 8'h3C, 8'h00);
    send_request(REQ_DATA, 8'h3C, 8'h00);
    send_request(REQ_CLOSE, 8'h3C, 8'h7E);
    drain();

    run_phase(0, 0, 1'b1);
    run_phase(88, 0, 1'b0);
    run_phase(0, 88, 1'b0);
    run_phase(31, 31, 1'b0);

    byte_req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== multi_channel_length_prefix_deframer.f =====
src/dfr_pkg.sv
src/dfr_if.sv
src/dfr_state_store.sv
src/dfr_out_reg.sv
src/multi_channel_length_prefix_deframer.sv
src/dfr_checker.sv
tb/dfr_checker.sv
tb/tb.sv
